>>> design/mrpt_pkg.sv
// Shared types, constants and helpers for the 64-bit Miller-Rabin prime test.
`timescale 1ns / 1ps

package mrpt_pkg;

   localparam int NUM_BITS_DEFAULT = 64;
   localparam int CANDIDATE_WIDTH  = 64;
   localparam int RSP_TDATA_WIDTH  = 8;

   // trial division primes 2..23
   localparam int NUM_TRIAL    = 9;
   localparam int PRIME_WIDTH  = 5;
   localparam logic [PRIME_WIDTH-1:0] TRIAL_PRIME [0:NUM_TRIAL-1] =
      '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23};

   // deterministic witness set
   localparam int NUM_BASES   = 7;
   localparam int BASE_WIDTH  = 31;
   localparam int BASE_IDX_W  = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIAL,
      ST_DECOMP,
      ST_BASE_START,
      ST_BASE_WAIT,
      ST_NEXT_BASE,
      ST_POW_STEP,
      ST_POW_MUL_WAIT,
      ST_POW_SQR,
      ST_POW_SQR_WAIT,
      ST_POW_TEST,
      ST_SQ_STEP,
      ST_SQ_WAIT,
      ST_FINISH
   } state_type;

   // trial division status toward the sequencer
   typedef struct packed {
      logic done;
      logic decided;   // below two or divisible by a small prime
      logic prime;     // verdict when decided
   } trial_status_type;

   function automatic logic [BASE_WIDTH-1:0] mr_base(input logic [BASE_IDX_W-1:0] idx);
      logic [BASE_WIDTH-1:0] val;
      case (idx)
         3'd0:    val = 31'd2;
         3'd1:    val = 31'd325;
         3'd2:    val = 31'd9375;
         3'd3:    val = 31'd28178;
         3'd4:    val = 31'd450775;
         3'd5:    val = 31'd9780504;
         3'd6:    val = 31'd1795265022;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> design/mrpt_trial.sv
// Bit-serial trial division of the candidate by the primes 2 through 23.
`timescale 1ns / 1ps

module mrpt_trial #(
   parameter int NUM_BITS = mrpt_pkg::NUM_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_BITS-1:0]        n,
   output mrpt_pkg::trial_status_type status
);

   localparam int CW = $clog2(NUM_BITS);
   localparam int PW = mrpt_pkg::PRIME_WIDTH;
   localparam int NT = mrpt_pkg::NUM_TRIAL;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] shift_ff, shift_in;
   logic [PW-1:0]       rem_ff [0:NT-1];
   logic [PW-1:0]       rem_in [0:NT-1];
   logic                small_ff, small_in;
   logic                below2_ff, below2_in;
   logic                any_zero;

   always_comb begin
      logic [PW:0] t;
      t         = '0;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      small_in  = small_ff;
      below2_in = below2_ff;
      for (int i = 0; i < NT; i++) begin
         rem_in[i] = rem_ff[i];
      end
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CW'(NUM_BITS - 1);
         shift_in  = n;
         small_in  = n inside {2, 3, 5, 7, 11, 13, 17, 19, 23};
         below2_in = (n < NUM_BITS'(2));
         for (int i = 0; i < NT; i++) begin
            rem_in[i] = '0;
         end
      end else if (busy_ff) begin
         // one candidate bit per cycle, MSB first: rem = (2*rem + bit) mod p
         for (int i = 0; i < NT; i++) begin
            t = {rem_ff[i], shift_ff[NUM_BITS-1]};
            if (t >= {1'b0, mrpt_pkg::TRIAL_PRIME[i]}) begin
               t = t - {1'b0, mrpt_pkg::TRIAL_PRIME[i]};
            end
            rem_in[i] = t[PW-1:0];
         end
         shift_in = {shift_ff[NUM_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_comb begin
      any_zero = 1'b0;
      for (int i = 0; i < NT; i++) begin
         if (rem_ff[i] == '0) begin
            any_zero = 1'b1;
         end
      end
   end

   assign status.done    = done_ff;
   assign status.decided = below2_ff | any_zero;
   assign status.prime   = small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      shift_ff  <= shift_in;
      small_ff  <= small_in;
      below2_ff <= below2_in;
      for (int i = 0; i < NT; i++) begin
         rem_ff[i] <= rem_in[i];
      end
   end

endmodule

>>> design/mrpt_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
`timescale 1ns / 1ps

module mrpt_mulmod #(
   parameter int NUM_BITS = mrpt_pkg::NUM_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] a,       // must be below m
   input  logic [NUM_BITS-1:0] b,
   input  logic [NUM_BITS-1:0] m,
   output logic                done,
   output logic [NUM_BITS-1:0] product
);

   localparam int CW = $clog2(NUM_BITS);
   localparam int W  = NUM_BITS + 3;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] acc_ff, acc_in;
   logic [NUM_BITS-1:0] a_ff, a_in;
   logic [NUM_BITS-1:0] b_ff, b_in;
   logic [NUM_BITS-1:0] m_ff, m_in;
   logic [W-1:0]        sum_w, m_w, dif1, dif2;

   // 2*acc + bit*a lies below 3m: subtract 0, m or 2m
   always_comb begin
      m_w   = {3'b000, m_ff};
      sum_w = {2'b00, acc_ff, 1'b0} + (b_ff[NUM_BITS-1] ? {3'b000, a_ff} : '0);
      dif1  = sum_w - m_w;
      dif2  = sum_w - {m_w[W-2:0], 1'b0};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_BITS - 1);
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         m_in    = m;
      end else if (busy_ff) begin
         if (!dif2[W-1]) begin
            acc_in = dif2[NUM_BITS-1:0];
         end else if (!dif1[W-1]) begin
            acc_in = dif1[NUM_BITS-1:0];
         end else begin
            acc_in = sum_w[NUM_BITS-1:0];
         end
         b_in = {b_ff[NUM_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

endmodule

>>> design/miller_rabin_prime_test_64_core.sv
// Top level: deterministic Miller-Rabin primality test of a 64-bit candidate.
// When trial division does not decide, n-1 = d*2^r is split, then per base
//   about 2*log2(d)+r modular multiplies, all through the one shared multiplier.
// Throughput: one request at a time; the next is taken once the verdict sits in the
//   output register, even if it has not been taken yet.
// Reset: synchronous, active high; clears the sequencer and output valid, no clearing pass.
`timescale 1ns / 1ps

module miller_rabin_prime_test_64_core #(
   parameter int NUM_BITS = mrpt_pkg::NUM_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mrpt_pkg::CANDIDATE_WIDTH-1:0] req_tdata,   // [63:0] candidate
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mrpt_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata    // [0] is_prime, [7:1] zero
);

   localparam int CW = $clog2(NUM_BITS);
   localparam int BW = mrpt_pkg::BASE_WIDTH;
   localparam int IW = mrpt_pkg::BASE_IDX_W;

   mrpt_pkg::state_type        state_ff, state_in;
   mrpt_pkg::trial_status_type trial_status;

   logic [NUM_BITS-1:0] n_ff, n_in;
   logic [NUM_BITS-1:0] nm1_ff, nm1_in;      // n - 1
   logic [NUM_BITS-1:0] d_ff, d_in;          // odd part of n - 1
   logic [CW-1:0]       r_ff, r_in;          // power of two in n - 1
   logic [CW-1:0]       j_ff, j_in;          // squaring count
   logic [NUM_BITS-1:0] e_ff, e_in;          // exponent shift register
   logic [NUM_BITS-1:0] x_ff, x_in;          // running power
   logic [NUM_BITS-1:0] y_ff, y_in;          // base squared up
   logic [IW-1:0]       idx_ff, idx_in;      // witness index
   logic                verdict_ff, verdict_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_bit_ff, rsp_bit_in;

   logic                req_accept;
   logic                mul_start;
   logic [NUM_BITS-1:0] mul_a, mul_b;
   logic                mul_done;
   logic [NUM_BITS-1:0] mul_product;
   logic [NUM_BITS-1:0] one_w;

   assign one_w      = {{(NUM_BITS-1){1'b0}}, 1'b1};
   assign req_tready = (state_ff == mrpt_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   mrpt_trial #(.NUM_BITS(NUM_BITS)) u_trial (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .n      (req_tdata[NUM_BITS-1:0]),
      .status (trial_status)
   );

   mrpt_mulmod #(.NUM_BITS(NUM_BITS)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .m       (n_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // Sequencer: trial division, n-1 split, then per witness a right-to-left
   // exponentiation and the squaring chain, both through the shared multiplier.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      verdict_in   = verdict_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mul_start    = 1'b0;
      mul_a        = x_ff;
      mul_b        = y_ff;

      case (state_ff)
         mrpt_pkg::ST_IDLE: begin
            if (req_accept) begin
               n_in     = req_tdata[NUM_BITS-1:0];
               state_in = mrpt_pkg::ST_TRIAL;
            end
         end

         mrpt_pkg::ST_TRIAL: begin
            if (trial_status.done) begin
               if (trial_status.decided) begin
                  verdict_in = trial_status.prime;
                  state_in   = mrpt_pkg::ST_FINISH;
               end else begin
                  nm1_in   = n_ff - one_w;
                  d_in     = n_ff - one_w;
                  r_in     = '0;
                  state_in = mrpt_pkg::ST_DECOMP;
               end
            end
         end

         // strip one factor of two per cycle
         mrpt_pkg::ST_DECOMP: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[NUM_BITS-1:1]};
               r_in = r_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = mrpt_pkg::ST_BASE_START;
            end
         end

         // witness mod n through the multiplier: 1 * base mod n
         mrpt_pkg::ST_BASE_START: begin
            mul_start = 1'b1;
            mul_a     = one_w;
            mul_b     = {{(NUM_BITS-BW){1'b0}}, mrpt_pkg::mr_base(idx_ff)};
            state_in  = mrpt_pkg::ST_BASE_WAIT;
         end

         mrpt_pkg::ST_BASE_WAIT: begin
            if (mul_done) begin
               if (mul_product == '0) begin
                  state_in = mrpt_pkg::ST_NEXT_BASE;   // witness is a multiple of n
               end else begin
                  y_in     = mul_product;
                  x_in     = one_w;
                  e_in     = d_ff;
                  state_in = mrpt_pkg::ST_POW_STEP;
               end
            end
         end

         mrpt_pkg::ST_NEXT_BASE: begin
            if (idx_ff == IW'(mrpt_pkg::NUM_BASES - 1)) begin
               verdict_in = 1'b1;
               state_in   = mrpt_pkg::ST_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = mrpt_pkg::ST_BASE_START;
            end
         end

         mrpt_pkg::ST_POW_STEP: begin
            if (e_ff == '0) begin
               state_in = mrpt_pkg::ST_POW_TEST;
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = y_ff;
               state_in  = mrpt_pkg::ST_POW_MUL_WAIT;
            end else begin
               state_in = mrpt_pkg::ST_POW_SQR;
            end
         end

         mrpt_pkg::ST_POW_MUL_WAIT: begin
            if (mul_done) begin
               x_in     = mul_product;
               state_in = mrpt_pkg::ST_POW_SQR;
            end
         end

         // skip the final squaring of the base, nothing uses it
         mrpt_pkg::ST_POW_SQR: begin
            if (e_ff[NUM_BITS-1:1] == '0) begin
               state_in = mrpt_pkg::ST_POW_TEST;
            end else begin
               mul_start = 1'b1;
               mul_a     = y_ff;
               mul_b     = y_ff;
               state_in  = mrpt_pkg::ST_POW_SQR_WAIT;
            end
         end

         mrpt_pkg::ST_POW_SQR_WAIT: begin
            if (mul_done) begin
               y_in     = mul_product;
               e_in     = {1'b0, e_ff[NUM_BITS-1:1]};
               state_in = mrpt_pkg::ST_POW_STEP;
            end
         end

         mrpt_pkg::ST_POW_TEST: begin
            if (x_ff == one_w || x_ff == nm1_ff) begin
               state_in = mrpt_pkg::ST_NEXT_BASE;
            end else begin
               j_in     = CW'(1);
               state_in = mrpt_pkg::ST_SQ_STEP;
            end
         end

         mrpt_pkg::ST_SQ_STEP: begin
            if (j_ff >= r_ff) begin
               verdict_in = 1'b0;                    // witness proves composite
               state_in   = mrpt_pkg::ST_FINISH;
            end else begin
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = x_ff;
               state_in  = mrpt_pkg::ST_SQ_WAIT;
            end
         end

         mrpt_pkg::ST_SQ_WAIT: begin
            if (mul_done) begin
               x_in = mul_product;
               if (mul_product == nm1_ff) begin
                  state_in = mrpt_pkg::ST_NEXT_BASE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = mrpt_pkg::ST_SQ_STEP;
               end
            end
         end

         // hand the verdict to the output register once it is free
         mrpt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = verdict_ff;
               state_in     = mrpt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mrpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mrpt_pkg::RSP_TDATA_WIDTH-1){1'b0}}, rsp_bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      nm1_ff     <= nm1_in;
      d_ff       <= d_in;
      r_ff       <= r_in;
      j_ff       <= j_in;
      e_ff       <= e_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      idx_ff     <= idx_in;
      verdict_ff <= verdict_in;
      rsp_bit_ff <= rsp_bit_in;
   end

endmodule
